// ===== hdl/av1dd_pkg.sv =====
// ----------------------------------------------------------------------------
// av1dd_pkg
// Shared types and constants for the AV1 dependency descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none

package av1dd_pkg;

  localparam int unsigned MAX_TEMPLATES = 64;

  localparam int unsigned IN_W    = 8;
  localparam int unsigned TDATA_W = 96;
  localparam int unsigned TUSER_W = 4;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = QPTR_W + 1;

  // record kinds
  localparam logic [3:0] K_HEADER  = 4'd0;
  localparam logic [3:0] K_EXT     = 4'd1;
  localparam logic [3:0] K_LAYER   = 4'd2;
  localparam logic [3:0] K_DTI     = 4'd3;
  localparam logic [3:0] K_FDIFF   = 4'd4;
  localparam logic [3:0] K_DONE    = 4'd5;
  localparam logic [3:0] K_SHORT   = 4'd6;
  localparam logic [3:0] K_TRUNC   = 4'd7;
  localparam logic [3:0] K_TOOMANY = 4'd8;

  typedef struct packed {
    logic            last;
    logic [IN_W-1:0] data;
  } qent_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  flags;
    logic [5:0]  tid;
    logic [15:0] fnum;
    logic [5:0]  dtc;
    logic [31:0] active;
    logic [5:0]  tidx;
    logic [4:0]  tgt;
    logic [5:0]  spat;
    logic [5:0]  temp;
    logic [4:0]  code;
  } rec_t;

  // one parser action: optional record, and whether the byte's run ends here
  typedef struct packed {
    logic rec_v;
    logic fin;
    rec_t rec;
  } ev_t;

endpackage

`default_nettype wire

// ===== hdl/av1_dependency_descriptor_parser.sv =====
// Path: an accepted byte passes the input queue, the parser and the hold stage to the
//   output register; a byte's final record leaves once its run closes.
// Header and ignored bytes take a parser step each, a third header byte with tlast adds
//   a done step; other bytes take a fetch step, a step per field and a run-end step,
//   plus a too-many step on template overflow. Reset: rst_ni asynchronous active low,
//   empties queue and output, parser returns to the mandatory header.
// ----------------------------------------------------------------------------
// av1_dependency_descriptor_parser
// AV1 RTP dependency descriptor parser: byte stream in, field records out.
// ----------------------------------------------------------------------------
`default_nettype none

module av1_dependency_descriptor_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [av1dd_pkg::IN_W-1:0]    s_axis_tdata,  // [7:0] data_byte
  input  wire logic                          s_axis_tlast,  // last_byte
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [4:0] flags, [10:5] template_id, [26:11] frame_number, [32:27] dt_count,
  // [64:33] active_targets, [70:65] template_idx, [75:71] target_index,
  // [81:76] spatial_layer, [87:82] temporal_layer, [92:88] code_value
  output      logic [av1dd_pkg::TDATA_W-1:0] m_axis_tdata,
  output      logic [av1dd_pkg::TUSER_W-1:0] m_axis_tuser,  // [3:0] kind
  output      logic                          m_axis_tlast   // last
);

  logic             q_valid, q_pop;
  av1dd_pkg::qent_t q_ent;
  logic             ev_valid, ev_ready;
  av1dd_pkg::ev_t   ev;

  av1dd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_valid_o     (q_valid),
    .q_ent_o       (q_ent),
    .q_pop_i       (q_pop)
  );

  av1dd_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ent_i    (q_ent),
    .q_pop_o    (q_pop),
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .ev_ready_i (ev_ready)
  );

  av1dd_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_valid_i    (ev_valid),
    .ev_i          (ev),
    .ev_ready_o    (ev_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/av1dd_front.sv =====
// ----------------------------------------------------------------------------
// av1dd_front
// Ingress side: takes descriptor bytes and queues them for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module av1dd_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [av1dd_pkg::IN_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic                        s_axis_tlast,   // last_byte
  output      logic                        q_valid_o,
  output      av1dd_pkg::qent_t            q_ent_o,
  input  wire logic                        q_pop_i
);

  av1dd_pkg::qent_t                 mem_q [av1dd_pkg::QDEPTH];
  logic [av1dd_pkg::QPTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [av1dd_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                             push, pop;

  assign s_axis_tready = (cnt_q != av1dd_pkg::QCNT_W'(av1dd_pkg::QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_ent_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{last: s_axis_tlast, data: s_axis_tdata};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/av1dd_parse.sv =====
// ----------------------------------------------------------------------------
// av1dd_parse
// Parser core: pulls queued bytes, extracts one field per cycle from the bit
// buffer, one action (record and/or run end) per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module av1dd_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire av1dd_pkg::qent_t  q_ent_i,
  output      logic              q_pop_o,
  output      logic              ev_valid_o,
  output      av1dd_pkg::ev_t    ev_o,
  input  wire logic              ev_ready_i
);

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_EXT    = 4'd1;
  localparam logic [3:0] PH_OFFSET = 4'd2;
  localparam logic [3:0] PH_LAYERS = 4'd3;
  localparam logic [3:0] PH_DTI    = 4'd4;
  localparam logic [3:0] PH_FFLAG  = 4'd5;
  localparam logic [3:0] PH_FVAL   = 4'd6;
  localparam logic [3:0] PH_DONE   = 4'd7;
  localparam logic [3:0] PH_SKIP   = 4'd8;

  localparam logic [1:0] M_FETCH   = 2'd0;
  localparam logic [1:0] M_DRAIN   = 2'd1;
  localparam logic [1:0] M_HDONE   = 2'd2;
  localparam logic [1:0] M_TOOMANY = 2'd3;

  logic [1:0]  mode_q, mode_d;
  logic [3:0]  phase_q, phase_d;
  logic [1:0]  bc_q, bc_d;
  logic [15:0] hs_q, hs_d;
  logic [15:0] acc_q, acc_d;
  logic [4:0]  held_q, held_d;
  logic [4:0]  extf_q, extf_d;
  logic [5:0]  tcnt_q, tcnt_d;
  logic [6:0]  tmpl_cnt_q, tmpl_cnt_d;
  logic [6:0]  cur_tmpl_q, cur_tmpl_d;
  logic [4:0]  cur_tgt_q, cur_tgt_d;
  logic [5:0]  sp_q, sp_d;
  logic [5:0]  tp_q, tp_d;
  logic        last_q, last_d;

  logic [3:0]  need;
  logic        have_field;
  logic [4:0]  sh;
  logic [15:0] shifted;
  logic [15:0] acc_rem;
  logic [4:0]  fetch_held;
  logic [6:0]  tc_n;
  logic [5:0]  tgt_n;
  logic [5:0]  tcnt_new;
  logic        act, go, clr;
  av1dd_pkg::ev_t ev;

  always_comb begin
    case (phase_q)
      PH_EXT:    need = 4'd5;
      PH_OFFSET: need = 4'd11;
      PH_LAYERS: need = 4'd2;
      PH_DTI:    need = 4'd2;
      PH_FFLAG:  need = 4'd1;
      PH_FVAL:   need = 4'd4;
      default:   need = 4'd0;
    endcase
  end

  assign have_field = (need != 4'd0) && (held_q >= {1'b0, need});
  assign sh         = held_q - {1'b0, need};
  assign shifted    = acc_q >> sh;
  assign acc_rem    = acc_q & ~(16'hFFFF << sh);
  assign fetch_held = (held_q > 5'd8) ? 5'd16 : held_q + 5'd8;
  assign tc_n       = cur_tmpl_q + 7'd1;
  assign tgt_n      = {1'b0, cur_tgt_q} + 6'd1;
  assign tcnt_new   = {1'b0, shifted[4:0]} + 6'd1;

  always_comb begin
    mode_d     = mode_q;
    phase_d    = phase_q;
    bc_d       = bc_q;
    hs_d       = hs_q;
    acc_d      = acc_q;
    held_d     = held_q;
    extf_d     = extf_q;
    tcnt_d     = tcnt_q;
    tmpl_cnt_d = tmpl_cnt_q;
    cur_tmpl_d = cur_tmpl_q;
    cur_tgt_d  = cur_tgt_q;
    sp_d       = sp_q;
    tp_d       = tp_q;
    last_d     = last_q;
    act        = 1'b0;
    clr        = 1'b0;
    ev         = '0;

    case (mode_q)
      M_FETCH: begin
        act = q_valid_i;
        if (phase_q == PH_HEADER) begin
          if (bc_q != 2'd2) begin
            hs_d = {hs_q[7:0], q_ent_i.data};
            bc_d = bc_q + 2'd1;
            if (q_ent_i.last) begin
              ev.rec_v    = 1'b1;
              ev.fin      = 1'b1;
              ev.rec.kind = av1dd_pkg::K_SHORT;
              clr         = 1'b1;
            end
          end else begin
            ev.rec_v     = 1'b1;
            ev.rec.kind  = av1dd_pkg::K_HEADER;
            ev.rec.flags = {3'b000, hs_q[15:14]};
            ev.rec.tid   = hs_q[13:8];
            ev.rec.fnum  = {hs_q[7:0], q_ent_i.data};
            bc_d         = 2'd0;
            phase_d      = PH_EXT;
            acc_d        = '0;
            held_d       = '0;
            if (q_ent_i.last) begin
              mode_d = M_HDONE;
            end else begin
              ev.fin = 1'b1;
            end
          end
        end else if (phase_q >= PH_DONE) begin
          acc_d  = '0;
          held_d = '0;
          ev.fin = 1'b1;
          if (q_ent_i.last) begin
            clr = 1'b1;
            if (phase_q == PH_DONE) begin
              ev.rec_v    = 1'b1;
              ev.rec.kind = av1dd_pkg::K_DONE;
            end
          end
        end else begin
          acc_d  = {acc_q[7:0], q_ent_i.data};
          held_d = fetch_held;
          last_d = q_ent_i.last;
          mode_d = M_DRAIN;
        end
      end

      M_HDONE: begin
        act         = 1'b1;
        ev.rec_v    = 1'b1;
        ev.fin      = 1'b1;
        ev.rec.kind = av1dd_pkg::K_DONE;
        clr         = 1'b1;
        mode_d      = M_FETCH;
      end

      M_TOOMANY: begin
        act         = 1'b1;
        ev.rec_v    = 1'b1;
        ev.rec.kind = av1dd_pkg::K_TOOMANY;
        mode_d      = M_DRAIN;
      end

      M_DRAIN: begin
        act = 1'b1;
        if (have_field) begin
          acc_d  = acc_rem;
          held_d = sh;
          case (phase_q)
            PH_EXT: begin
              extf_d = shifted[4:0];
              if (shifted[4]) begin
                phase_d = PH_OFFSET;
              end else begin
                ev.rec_v     = 1'b1;
                ev.rec.kind  = av1dd_pkg::K_EXT;
                ev.rec.flags = shifted[4:0];
                phase_d      = PH_DONE;
              end
            end
            PH_OFFSET: begin
              tcnt_d        = tcnt_new;
              ev.rec_v      = 1'b1;
              ev.rec.kind   = av1dd_pkg::K_EXT;
              ev.rec.flags  = extf_q;
              ev.rec.tid    = shifted[10:5];
              ev.rec.dtc    = tcnt_new;
              ev.rec.active = 32'hFFFF_FFFF >> (6'd32 - tcnt_new);
              tmpl_cnt_d    = '0;
              cur_tmpl_d    = '0;
              cur_tgt_d     = '0;
              sp_d          = '0;
              tp_d          = '0;
              phase_d       = PH_LAYERS;
            end
            PH_LAYERS: begin
              ev.rec_v    = 1'b1;
              ev.rec.kind = av1dd_pkg::K_LAYER;
              ev.rec.tidx = cur_tmpl_q[5:0];
              ev.rec.spat = sp_q;
              ev.rec.temp = tp_q;
              tmpl_cnt_d  = tc_n;
              if (shifted[1:0] == 2'd3) begin
                cur_tmpl_d = '0;
                cur_tgt_d  = '0;
                phase_d    = PH_DTI;
              end else if (tc_n >= 7'(av1dd_pkg::MAX_TEMPLATES)) begin
                phase_d = PH_SKIP;
                acc_d   = '0;
                held_d  = '0;
                mode_d  = M_TOOMANY;
              end else begin
                if (shifted[1:0] == 2'd1) begin
                  tp_d = tp_q + 6'd1;
                end else if (shifted[1:0] == 2'd2) begin
                  tp_d = '0;
                  sp_d = sp_q + 6'd1;
                end
                cur_tmpl_d = tc_n;
              end
            end
            PH_DTI: begin
              ev.rec_v    = 1'b1;
              ev.rec.kind = av1dd_pkg::K_DTI;
              ev.rec.tidx = cur_tmpl_q[5:0];
              ev.rec.tgt  = cur_tgt_q;
              ev.rec.code = {3'b000, shifted[1:0]};
              if (tgt_n >= tcnt_q) begin
                cur_tgt_d = '0;
                if (tc_n >= tmpl_cnt_q) begin
                  cur_tmpl_d = '0;
                  phase_d    = PH_FFLAG;
                end else begin
                  cur_tmpl_d = tc_n;
                end
              end else begin
                cur_tgt_d = tgt_n[4:0];
              end
            end
            PH_FFLAG: begin
              if (shifted[0]) begin
                phase_d = PH_FVAL;
              end else if (tc_n >= tmpl_cnt_q) begin
                cur_tmpl_d = '0;
                phase_d    = PH_DONE;
                acc_d      = '0;
                held_d     = '0;
              end else begin
                cur_tmpl_d = tc_n;
              end
            end
            PH_FVAL: begin
              ev.rec_v    = 1'b1;
              ev.rec.kind = av1dd_pkg::K_FDIFF;
              ev.rec.tidx = cur_tmpl_q[5:0];
              ev.rec.code = {1'b0, shifted[3:0]} + 5'd1;
              phase_d     = PH_FFLAG;
            end
            default: begin
              acc_d  = '0;
              held_d = '0;
            end
          endcase
        end else begin
          // end of this byte's run
          if (phase_q == PH_DONE) begin
            acc_d  = '0;
            held_d = '0;
          end
          mode_d = M_FETCH;
          ev.fin = 1'b1;
          if (last_q) begin
            clr = 1'b1;
            if (phase_q == PH_DONE) begin
              ev.rec_v    = 1'b1;
              ev.rec.kind = av1dd_pkg::K_DONE;
            end else if (phase_q != PH_SKIP) begin
              ev.rec_v    = 1'b1;
              ev.rec.kind = av1dd_pkg::K_TRUNC;
            end
          end
        end
      end

      default: begin
        mode_d = M_FETCH;
      end
    endcase

    if (clr) begin
      phase_d    = PH_HEADER;
      bc_d       = '0;
      hs_d       = '0;
      acc_d      = '0;
      held_d     = '0;
      extf_d     = '0;
      tcnt_d     = '0;
      tmpl_cnt_d = '0;
      cur_tmpl_d = '0;
      cur_tgt_d  = '0;
      sp_d       = '0;
      tp_d       = '0;
      last_d     = 1'b0;
    end
  end

  assign go         = act && ev_ready_i;
  assign q_pop_o    = go && (mode_q == M_FETCH);
  assign ev_valid_o = act;
  assign ev_o       = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_FETCH;
      phase_q    <= PH_HEADER;
      bc_q       <= '0;
      hs_q       <= '0;
      acc_q      <= '0;
      held_q     <= '0;
      extf_q     <= '0;
      tcnt_q     <= '0;
      tmpl_cnt_q <= '0;
      cur_tmpl_q <= '0;
      cur_tgt_q  <= '0;
      sp_q       <= '0;
      tp_q       <= '0;
      last_q     <= 1'b0;
    end else if (go) begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      bc_q       <= bc_d;
      hs_q       <= hs_d;
      acc_q      <= acc_d;
      held_q     <= held_d;
      extf_q     <= extf_d;
      tcnt_q     <= tcnt_d;
      tmpl_cnt_q <= tmpl_cnt_d;
      cur_tmpl_q <= cur_tmpl_d;
      cur_tgt_q  <= cur_tgt_d;
      sp_q       <= sp_d;
      tp_q       <= tp_d;
      last_q     <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/av1dd_emit.sv =====
// ----------------------------------------------------------------------------
// av1dd_emit
// Egress side: one-record hold stage that resolves the last flag, followed by
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module av1dd_emit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          ev_valid_i,
  input  wire av1dd_pkg::ev_t                ev_i,
  output      logic                          ev_ready_o,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [av1dd_pkg::TDATA_W-1:0] m_axis_tdata,
  output      logic [av1dd_pkg::TUSER_W-1:0] m_axis_tuser,
  output      logic                          m_axis_tlast
);

  av1dd_pkg::rec_t hold_q, out_q;
  logic            hold_v_q, hold_v_d;
  logic            hold_fin_q, hold_fin_d;
  logic            out_v_q, out_v_d;
  logic            out_last_q;
  logic            out_free, hold_go, ev_go;

  assign out_free   = !out_v_q || m_axis_tready;
  assign hold_go    = hold_v_q && out_free &&
                      (hold_fin_q || (ev_valid_i && ev_i.rec_v));
  assign ev_ready_o = !ev_i.rec_v || !hold_v_q || out_free;
  assign ev_go      = ev_valid_i && ev_ready_o;

  always_comb begin
    out_v_d    = out_v_q;
    hold_v_d   = hold_v_q && !hold_go;
    hold_fin_d = hold_fin_q;
    if (hold_go) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
    if (ev_go) begin
      if (ev_i.rec_v) begin
        hold_v_d   = 1'b1;
        hold_fin_d = ev_i.fin;
      end else if (ev_i.fin) begin
        hold_fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q   <= 1'b0;
      hold_fin_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      hold_v_q   <= hold_v_d;
      hold_fin_q <= hold_fin_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_go && ev_i.rec_v) begin
      hold_q <= ev_i.rec;
    end
    if (hold_go) begin
      out_q      <= hold_q;
      out_last_q <= hold_fin_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {3'b000, out_q.code, out_q.temp, out_q.spat, out_q.tgt,
                          out_q.tidx, out_q.active, out_q.dtc, out_q.fnum,
                          out_q.tid, out_q.flags};

endmodule

`default_nettype wire

// ===== hdl/av1dd_checker.sv =====
// ----------------------------------------------------------------------------
// av1dd_checker
// Port-level checks on the parser's record stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module av1dd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [av1dd_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic [av1dd_pkg::TUSER_W-1:0] m_axis_tuser,
  input wire logic                          m_axis_tlast
);

  logic beat;
  logic term_kind;
  logic idle_q;

  assign beat      = m_axis_tvalid && m_axis_tready;
  assign term_kind = (m_axis_tuser == av1dd_pkg::K_DONE) ||
                     (m_axis_tuser == av1dd_pkg::K_SHORT) ||
                     (m_axis_tuser == av1dd_pkg::K_TRUNC);

  // set between descriptors that close with a done, short or trunc record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= 1'b1;
    end else if (beat) begin
      idle_q <= term_kind;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && term_kind |-> m_axis_tlast)
    else $error("closing record without last");

  a_first_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && idle_q |->
      (m_axis_tuser == av1dd_pkg::K_HEADER) || (m_axis_tuser == av1dd_pkg::K_SHORT))
    else $error("descriptor does not open with header or short");

  a_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == av1dd_pkg::K_HEADER) |->
      (m_axis_tdata[95:27] == '0) && (m_axis_tdata[4:2] == '0) && !m_axis_tlast ||
      (m_axis_tvalid && (m_axis_tuser == av1dd_pkg::K_HEADER) &&
       (m_axis_tdata[95:27] == '0) && (m_axis_tdata[4:2] == '0)))
    else $error("header record carries stray fields");

  a_dti_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == av1dd_pkg::K_DTI) |->
      (m_axis_tdata[92:90] == '0))
    else $error("dti code out of range");

endmodule

bind av1_dependency_descriptor_parser av1dd_checker u_av1dd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/tb_av1_dependency_descriptor_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_av1_dependency_descriptor_parser
// Streams directed and random dependency descriptors into the parser, one
// byte per beat, predicts every field record in a behavioral model of the
// parser and checks the output stream record by record. Both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------

module tb_av1_dependency_descriptor_parser;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEM_TARGET = 130;

  typedef enum logic [3:0] {
    PH_HEADER, PH_EXT, PH_OFFSET, PH_LAYERS, PH_DTI, PH_FFLAG, PH_FVAL, PH_DONE, PH_SKIP
  } phase_e;

  typedef enum int {
    DD_SHORT, DD_HDR_ONLY, DD_NO_STRUCT, DD_FULL, DD_TRUNC, DD_TOOMANY, DD_NOISE
  } dd_form_e;

  typedef struct packed {
    logic            last;
    av1dd_pkg::rec_t rec;
  } record_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [av1dd_pkg::IN_W-1:0]     s_axis_tdata = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [av1dd_pkg::TDATA_W-1:0]  m_axis_tdata;
  logic [av1dd_pkg::TUSER_W-1:0]  m_axis_tuser;
  logic                           m_axis_tlast;

  av1_dependency_descriptor_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  av1dd_pkg::qent_t byte_backlog[$];
  record_t          expected_records[$];
  bit               stream_bits[$];
  av1dd_pkg::rec_t  step_records[$];
  int unsigned      mismatches = 0;
  int unsigned      cycle_count = 0;

  // parser model state
  phase_e      phase = PH_HEADER;
  int unsigned hdr_cnt = 0;
  logic [23:0] hdr_bytes = '0;
  logic [31:0] acc = '0;
  int unsigned acc_bits = 0;
  logic [4:0]  ext_f = '0;
  int unsigned n_targets = 0;
  int unsigned n_templates = 0;
  int unsigned tpl = 0;
  int unsigned tgt = 0;
  int unsigned spat = 0;
  int unsigned temp = 0;

  function automatic av1dd_pkg::rec_t blank_record(logic [3:0] kind);
    av1dd_pkg::rec_t r = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic int unsigned field_width(phase_e p);
    case (p)
      PH_EXT:    return 5;
      PH_OFFSET: return 11;
      PH_LAYERS: return 2;
      PH_DTI:    return 2;
      PH_FFLAG:  return 1;
      PH_FVAL:   return 4;
      default:   return 0;
    endcase
  endfunction

  task automatic drop_bits();
    acc = '0;
    acc_bits = 0;
  endtask

  task automatic pull_bits(input int unsigned n, output logic [31:0] v);
    v = (acc >> (acc_bits - n)) & ((32'd1 << n) - 32'd1);
    acc_bits = acc_bits - n;
    acc = acc & ((32'd1 << acc_bits) - 32'd1);
  endtask

  task automatic clear_parser();
    phase = PH_HEADER;
    hdr_cnt = 0;
    hdr_bytes = '0;
    drop_bits();
    ext_f = '0;
    n_targets = 0;
    n_templates = 0;
    tpl = 0;
    tgt = 0;
    spat = 0;
    temp = 0;
  endtask

  task automatic parse_field();
    logic [31:0] v;
    logic [63:0] mask;
    av1dd_pkg::rec_t r;
    case (phase)
      PH_EXT: begin
        pull_bits(5, v);
        ext_f = v[4:0];
        if (v[4]) begin
          phase = PH_OFFSET;
        end else begin
          r = blank_record(av1dd_pkg::K_EXT);
          r.flags = v[4:0];
          step_records.insert(step_records.size(), r);
          phase = PH_DONE;
        end
      end
      PH_OFFSET: begin
        pull_bits(11, v);
        n_targets = v[4:0] + 1;
        mask = (64'd1 << n_targets) - 64'd1;
        r = blank_record(av1dd_pkg::K_EXT);
        r.flags = ext_f;
        r.tid = v[10:5];
        r.dtc = n_targets[5:0];
        r.active = mask[31:0];
        step_records.insert(step_records.size(), r);
        n_templates = 0;
        tpl = 0;
        tgt = 0;
        spat = 0;
        temp = 0;
        phase = PH_LAYERS;
      end
      PH_LAYERS: begin
        pull_bits(2, v);
        r = blank_record(av1dd_pkg::K_LAYER);
        r.tidx = tpl[5:0];
        r.spat = spat[5:0];
        r.temp = temp[5:0];
        step_records.insert(step_records.size(), r);
        n_templates = (tpl + 1) & 32'h7f;
        if (v == 3) begin
          tpl = 0;
          tgt = 0;
          phase = PH_DTI;
        end else if (n_templates >= av1dd_pkg::MAX_TEMPLATES) begin
          step_records.insert(step_records.size(), blank_record(av1dd_pkg::K_TOOMANY));
          phase = PH_SKIP;
          drop_bits();
        end else begin
          if (v == 1) begin
            temp = (temp + 1) & 32'h3f;
          end else if (v == 2) begin
            temp = 0;
            spat = (spat + 1) & 32'h3f;
          end
          tpl = (tpl + 1) & 32'h7f;
        end
      end
      PH_DTI: begin
        pull_bits(2, v);
        r = blank_record(av1dd_pkg::K_DTI);
        r.tidx = tpl[5:0];
        r.tgt = tgt[4:0];
        r.code = v[4:0];
        step_records.insert(step_records.size(), r);
        if (tgt + 1 >= n_targets) begin
          tgt = 0;
          tpl = (tpl + 1) & 32'h7f;
          if (tpl >= n_templates) begin
            tpl = 0;
            phase = PH_FFLAG;
          end
        end else begin
          tgt = (tgt + 1) & 32'h1f;
        end
      end
      PH_FFLAG: begin
        pull_bits(1, v);
        if (v[0]) begin
          phase = PH_FVAL;
        end else begin
          tpl = (tpl + 1) & 32'h7f;
          if (tpl >= n_templates) begin
            tpl = 0;
            phase = PH_DONE;
            drop_bits();
          end
        end
      end
      PH_FVAL: begin
        pull_bits(4, v);
        r = blank_record(av1dd_pkg::K_FDIFF);
        r.tidx = tpl[5:0];
        r.code = v[4:0] + 5'd1;
        step_records.insert(step_records.size(), r);
        phase = PH_FFLAG;
      end
      default: drop_bits();
    endcase
  endtask

  task automatic predict_descriptor_byte(input logic [7:0] b, input logic last);
    av1dd_pkg::rec_t r;
    record_t e;
    step_records.delete();
    if (phase == PH_HEADER) begin
      hdr_bytes = {hdr_bytes[15:0], b};
      hdr_cnt++;
      if (hdr_cnt < 3) begin
        if (last) begin
          step_records.insert(step_records.size(), blank_record(av1dd_pkg::K_SHORT));
          clear_parser();
        end
      end else begin
        hdr_cnt = 0;
        r = blank_record(av1dd_pkg::K_HEADER);
        r.flags = {3'b000, hdr_bytes[23:22]};
        r.tid = hdr_bytes[21:16];
        r.fnum = hdr_bytes[15:0];
        step_records.insert(step_records.size(), r);
        phase = PH_EXT;
        drop_bits();
        if (last) begin
          step_records.insert(step_records.size(), blank_record(av1dd_pkg::K_DONE));
          clear_parser();
        end
      end
    end else begin
      if (phase == PH_DONE || phase == PH_SKIP) begin
        drop_bits();
      end else begin
        acc = ((acc << 8) | b) & 32'hffff;
        acc_bits += 8;
        if (acc_bits > 16) acc_bits = 16;
        while (field_width(phase) != 0 && acc_bits >= field_width(phase)) parse_field();
        if (phase == PH_DONE) drop_bits();
      end
      if (last) begin
        if (phase == PH_DONE) begin
          step_records.insert(step_records.size(), blank_record(av1dd_pkg::K_DONE));
        end else if (phase != PH_SKIP) begin
          step_records.insert(step_records.size(), blank_record(av1dd_pkg::K_TRUNC));
        end
        clear_parser();
      end
    end
    for (int i = 0; i < step_records.size(); i++) begin
      e.rec = step_records[i];
      e.last = (i == step_records.size() - 1);
      expected_records.insert(expected_records.size(), e);
    end
  endtask

  task automatic match_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_record(input record_t e);
    match_field("kind", 64'(e.rec.kind), 64'(m_axis_tuser));
    match_field("flags", 64'(e.rec.flags), 64'(m_axis_tdata[4:0]));
    match_field("template_id", 64'(e.rec.tid), 64'(m_axis_tdata[10:5]));
    match_field("frame_number", 64'(e.rec.fnum), 64'(m_axis_tdata[26:11]));
    match_field("dt_count", 64'(e.rec.dtc), 64'(m_axis_tdata[32:27]));
    match_field("active_targets", 64'(e.rec.active), 64'(m_axis_tdata[64:33]));
    match_field("template_idx", 64'(e.rec.tidx), 64'(m_axis_tdata[70:65]));
    match_field("target_index", 64'(e.rec.tgt), 64'(m_axis_tdata[75:71]));
    match_field("spatial_layer", 64'(e.rec.spat), 64'(m_axis_tdata[81:76]));
    match_field("temporal_layer", 64'(e.rec.temp), 64'(m_axis_tdata[87:82]));
    match_field("code_value", 64'(e.rec.code), 64'(m_axis_tdata[92:88]));
    match_field("last", 64'(e.last), 64'(m_axis_tlast));
  endtask

  // ---- stimulus construction ----

  task automatic push_byte(input logic [7:0] data, input logic last);
    av1dd_pkg::qent_t q;
    q.data = data;
    q.last = last;
    byte_backlog.insert(byte_backlog.size(), q);
  endtask

  task automatic push_bits(input logic [31:0] value, input int width);
    for (int i = width - 1; i >= 0; i--) stream_bits.insert(stream_bits.size(), value[i]);
  endtask

  // pads to whole bytes with random trailing bits; keeps the first keep bytes
  task automatic emit_stream(input int keep);
    int total;
    logic [7:0] b;
    while (stream_bits.size() % 8 != 0) begin
      stream_bits.insert(stream_bits.size(), 1'($urandom_range(0, 1)));
    end
    total = stream_bits.size() / 8;
    if (keep < 0 || keep > total) keep = total;
    b = '0;
    for (int i = 0; i < keep; i++) begin
      for (int j = 0; j < 8; j++) b = {b[6:0], stream_bits.pop_front()};
      push_byte(b, i == keep - 1);
    end
    stream_bits.delete();
  endtask

  task automatic queue_descriptor(input dd_form_e form, input int dtc_req, input int tpl_req);
    int n;
    int dtc;
    int ntpl;
    int k;
    stream_bits.delete();
    case (form)
      DD_SHORT: begin
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == n - 1);
      end
      DD_HDR_ONLY: begin
        for (int i = 0; i < 3; i++) push_byte(8'($urandom_range(0, 255)), i == 2);
      end
      DD_NOISE: begin
        n = $urandom_range(4, 9);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == n - 1);
      end
      DD_NO_STRUCT: begin
        for (int i = 0; i < 3; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_bits(32'({1'b0, 4'($urandom_range(0, 15))}), 5);
        push_bits($urandom, $urandom_range(0, 20));
        emit_stream(-1);
      end
      default: begin
        for (int i = 0; i < 3; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
        if (dtc_req > 0) dtc = dtc_req;
        else if ($urandom_range(0, 3) == 0) dtc = $urandom_range(1, 32);
        else dtc = $urandom_range(1, 4);
        if (form == DD_TOOMANY) ntpl = av1dd_pkg::MAX_TEMPLATES;
        else if (tpl_req > 0) ntpl = tpl_req;
        else if (dtc > 4) ntpl = $urandom_range(1, 3);
        else if ($urandom_range(0, 7) == 0) ntpl = $urandom_range(7, 20);
        else ntpl = $urandom_range(1, 6);
        push_bits(32'({1'b1, 4'($urandom_range(0, 15))}), 5);
        push_bits($urandom_range(0, 63), 6);
        push_bits(dtc - 1, 5);
        if (form == DD_TOOMANY) begin
          for (int i = 0; i < ntpl; i++) push_bits($urandom_range(0, 2), 2);
          push_bits($urandom, $urandom_range(0, 24));
        end else begin
          for (int i = 0; i < ntpl - 1; i++) push_bits($urandom_range(0, 2), 2);
          push_bits(3, 2);
          for (int i = 0; i < ntpl * dtc; i++) push_bits($urandom_range(0, 3), 2);
          for (int i = 0; i < ntpl; i++) begin
            k = (ntpl > 20) ? 0 : $urandom_range(0, 2);
            for (int j = 0; j < k; j++) begin
              push_bits(32'({1'b1, 4'($urandom_range(0, 15))}), 5);
            end
            push_bits(0, 1);
          end
          push_bits($urandom, $urandom_range(0, 9));
        end
        if (form == DD_TRUNC) emit_stream($urandom_range(1, (stream_bits.size() + 7) / 8 - 1));
        else emit_stream(-1);
      end
    endcase
  endtask

  task automatic queue_random_descriptor();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      queue_descriptor(DD_FULL, 0, 0);
    else if (pick < 62) queue_descriptor(DD_TRUNC, 0, 0);
    else if (pick < 70) queue_descriptor(DD_NO_STRUCT, 0, 0);
    else if (pick < 76) queue_descriptor(DD_SHORT, 0, 0);
    else if (pick < 81) queue_descriptor(DD_HDR_ONLY, 0, 0);
    else if (pick < 93) queue_descriptor(DD_NOISE, 0, 0);
    else                queue_descriptor(DD_TOOMANY, 0, 0);
  endtask

  // ---- byte driver ----

  av1dd_pkg::qent_t beat;
  int               gap_left = 0;
  bit               in_calm = 1'b0;
  bit               byte_taken = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !byte_taken)) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (byte_backlog.size() > 0) begin
        beat = byte_backlog.pop_front();
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat.data;
        s_axis_tlast <= beat.last;
        gap_left <= in_calm ? 0 : $urandom_range(0, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---- result ready ----

  int stall_left = 0;
  bit out_calm = 1'b0;
  bit result_taken = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        stall_left = out_calm ? 0 : $urandom_range(0, 12);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---- monitor and checker ----

  record_t head;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      byte_taken <= s_axis_tvalid && s_axis_tready;
      result_taken <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready) predict_descriptor_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_records.size() == 0) begin
          $error("record with no expectation: kind %0d", m_axis_tuser);
          mismatches++;
        end else begin
          head = expected_records.pop_front();
          check_record(head);
        end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    // short on first byte, short on second byte
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);
    // header only, all ones
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    // no structure, trailing bits ignored
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h78, 1'b1);
    // structure: max offset, one target, one template, fdiffs 16 and 1
    push_byte(8'h80, 1'b0);
    push_byte(8'h3f, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'he0, 1'b0);
    push_byte(8'hef, 1'b0);
    push_byte(8'hc0, 1'b1);
    // truncated inside the offset field
    push_byte(8'h40, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);

    queue_descriptor(DD_TOOMANY, 1, 0);
    queue_descriptor(DD_FULL, 32, 1);
    queue_descriptor(DD_FULL, 1, av1dd_pkg::MAX_TEMPLATES);
    while (byte_backlog.size() < ITEM_TARGET) queue_random_descriptor();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_backlog.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== av1_dependency_descriptor_parser.f =====
hdl/av1dd_pkg.sv
hdl/av1dd_front.sv
hdl/av1dd_parse.sv
hdl/av1dd_emit.sv
hdl/av1_dependency_descriptor_parser.sv
hdl/av1dd_checker.sv
dv/tb_av1_dependency_descriptor_parser.sv
